>>> src/jke_pkg.sv
package jke_pkg;

  // control counts
  localparam int AXES    = 8;
  localparam int BUTTONS = 8;
  localparam int HATS    = 2;

  localparam int AXIS_IW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int BTN_IW  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int HAT_IW  = (HATS > 1) ? $clog2(HATS) : 1;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_THRESHOLD  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_PWM_EN     = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_PWM_STEP   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_AF_EN      = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_AF_PERIOD  = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_AF_PULSE   = 3'd6;

  // autofire counter width and remainder steps
  localparam int AF_W   = 16;
  localparam int STEP_W = $clog2(AF_W);

  // key code bases
  localparam logic [4:0] KEY_BUTTON_BASE = 5'd16;
  localparam logic [4:0] KEY_HAT_BASE    = 5'd24;

  // hysteresis: Q15 to sample scale drops the threshold by one above half
  localparam logic [14:0] THR_HALF = 15'd16384;
  localparam logic [16:0] Q15_ONE  = 17'd32768;

  typedef enum logic [1:0] {
    FN_TICK,
    FN_AXIS,
    FN_BUTTON,
    FN_HAT
  } func_t;

  typedef enum logic [1:0] {
    AX_CENTER,
    AX_POS,
    AX_NEG
  } axis_key_t;

  typedef struct packed {
    func_t              func;
    logic [2:0]         control_index;
    logic signed [15:0] axis_value;
    logic               button_level;
    logic [3:0]         hat_bits;
  } jke_in_t;

  typedef struct packed {
    logic [4:0] key_index;
    logic       pressed;
    logic       last_event;
  } jke_out_t;

  typedef struct packed {
    logic [4:0] key_index;
    logic       pressed;
  } key_ev_t;

  localparam int MAX_EV = 4;

  // events of one request; last is the position of the final event
  typedef struct packed {
    logic [1:0]              last;
    key_ev_t [MAX_EV-1:0]    ev;
  } ev_group_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

>>> src/jke_mod.sv
// Restoring remainder, one dividend bit per cycle.
module jke_mod import jke_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AF_W-1:0] dividend,
  input  logic [AF_W-1:0] divisor,
  output mod_stat_t       stat,
  output logic [AF_W-1:0] rem
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [AF_W-1:0]   dvd;
  logic [AF_W-1:0]   dsr;
  logic [AF_W-1:0]   r;
  logic [AF_W:0]     sh;
  logic [AF_W-1:0]   r_new;

  always_comb begin
    sh = {r, dvd[AF_W-1]};
    // r < dsr, so one subtract keeps the partial remainder below dsr
    if (sh >= {1'b0, dsr}) begin
      r_new = AF_W'(sh - {1'b0, dsr});
    end else begin
      r_new = sh[AF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(AF_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      r   <= '0;
    end else if (busy) begin
      dvd <= {dvd[AF_W-2:0], 1'b0};
      r   <= r_new;
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy && (step == STEP_W'(AF_W - 1));
  assign rem       = r_new;

endmodule

>>> src/jke_front.sv
module jke_front import jke_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  jke_in_t           in_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output logic              push,
  output ev_group_t         push_data,
  input  logic              q_full
);

  // configuration
  logic            enable;
  logic [14:0]     thr;
  logic [14:0]     thr_next;
  logic            pwm_en;
  logic [15:0]     pwm_step;
  logic            af_en;
  logic [AF_W-1:0] af_period;
  logic [AF_W-1:0] af_pulse;

  // block state
  logic [15:0]        axis_last [AXES];
  axis_key_t          axis_st   [AXES];
  logic [BUTTONS-1:0] btn_last;
  logic [BUTTONS-1:0] btn_rep;
  logic [3:0]         hat_last  [HATS];
  logic [15:0]        phase;
  logic [15:0]        phase_next;
  logic [AF_W-1:0]    af_count;
  logic [AF_W-1:0]    af_raw;
  logic [31:0]        prod;
  logic [31:0]        prod_next;
  logic [15:0]        pdiff;

  // classify stage
  logic    s1_valid;
  logic    s1_act;
  jke_in_t s1;
  logic    acc;
  logic    exec;
  logic    range_ok;

  // remainder unit
  logic            mod_start;
  logic [AF_W-1:0] mod_divisor;
  logic [AF_W-1:0] mod_rem;
  mod_stat_t       mst;

  // execute results
  logic [AXIS_IW-1:0]     ai;
  logic [BTN_IW-1:0]      bi;
  logic [HAT_IW-1:0]      hi;
  axis_key_t              st_new;
  logic                   btn_out;
  logic                   btn_clr_cnt;
  logic [2:0]             n_ev;
  key_ev_t [MAX_EV-1:0]   ev;
  logic                   do_tick;
  logic [AF_W:0]          cnt_inc;
  logic [AF_W-1:0]        cnt_wrap;
  logic [AF_W-1:0]        period_eff;

  assign thr_next = (cfg_we && cfg_index == CFG_THRESHOLD) ? cfg_data[14:0] : thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      thr       <= 15'd16384;
      pwm_en    <= 1'b0;
      pwm_step  <= '0;
      af_en     <= 1'b0;
      af_period <= AF_W'(1000);
      af_pulse  <= AF_W'(500);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:    enable    <= cfg_data[0];
        CFG_THRESHOLD: thr       <= cfg_data[14:0];
        CFG_PWM_EN:    pwm_en    <= cfg_data[0];
        CFG_PWM_STEP:  pwm_step  <= cfg_data;
        CFG_AF_EN:     af_en     <= cfg_data[0];
        CFG_AF_PERIOD: af_period <= cfg_data;
        CFG_AF_PULSE:  af_pulse  <= cfg_data;
        default: ;
      endcase
    end
  end

  // new period: reduce the count as last stored by a tick or button, then
  // ticks keep it below the period
  assign mod_start   = cfg_we && (cfg_index == CFG_AF_PERIOD);
  assign mod_divisor = (cfg_data == '0) ? AF_W'(1) : cfg_data;

  jke_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (af_raw),
    .divisor  (mod_divisor),
    .stat     (mst),
    .rem      (mod_rem)
  );

  assign in_stall = mst.busy || (s1_valid && q_full);
  assign acc      = in_valid && !in_stall;
  assign exec     = s1_valid && !q_full;

  always_comb begin
    case (in_data.func)
      FN_TICK:   range_ok = 1'b1;
      FN_AXIS:   range_ok = {1'b0, in_data.control_index} < 4'(AXES);
      FN_BUTTON: range_ok = {1'b0, in_data.control_index} < 4'(BUTTONS);
      FN_HAT:    range_ok = {1'b0, in_data.control_index} < 4'(HATS);
      default:   range_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (exec) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1     <= in_data;
      s1_act <= enable && range_ok;
    end
  end

  assign ai = s1.control_index[AXIS_IW-1:0];
  assign bi = s1.control_index[BTN_IW-1:0];
  assign hi = s1.control_index[HAT_IW-1:0];

  assign do_tick    = exec && s1_act && (s1.func == FN_TICK);
  assign phase_next = do_tick ? phase + pwm_step : phase;
  assign pdiff      = 16'(Q15_ONE - {2'b0, thr_next});
  // product tracks the phase and threshold that the next executed request sees
  assign prod_next  = 32'(phase_next) * 32'(pdiff);

  assign period_eff = (af_period == '0) ? AF_W'(1) : af_period;
  assign cnt_inc    = {1'b0, af_count} + 1'b1;
  assign cnt_wrap   = (cnt_inc == {1'b0, period_eff}) ? '0 : cnt_inc[AF_W-1:0];

  always_comb begin
    logic signed [16:0] v17;
    logic signed [16:0] prev17;
    logic signed [16:0] tp;
    logic signed [16:0] tn;
    logic signed [16:0] vneg;
    logic [14:0]        thr_t;
    logic [32:0]        lvl;
    logic [32:0]        pos_mag;
    logic [32:0]        neg_mag;
    axis_key_t          st;
    axis_key_t          ns;
    logic [4:0]         kn;
    logic [4:0]         kp;
    logic               on;
    logic               rise;
    logic [3:0]         nb;
    logic [3:0]         ch;
    logic [4:0]         hbase;

    n_ev        = '0;
    ev          = '0;
    st_new      = axis_st[ai];
    btn_out     = btn_rep[bi];
    btn_clr_cnt = 1'b0;

    v17     = 17'(s1.axis_value);
    prev17  = 17'(signed'(axis_last[ai]));
    thr_t   = thr - 15'(thr > THR_HALF);
    tp      = signed'({2'b0, thr_t});
    tn      = -tp;
    vneg    = -v17;
    lvl     = 33'(prod) + {3'b0, thr, 15'b0};
    pos_mag = {2'b0, s1.axis_value[14:0], 16'b0};
    neg_mag = {vneg, 16'b0};
    st      = axis_st[ai];
    ns      = AX_CENTER;
    kn      = 5'({ai, 1'b0});
    kp      = 5'({ai, 1'b1});

    on    = af_count < af_pulse;
    rise  = s1.button_level && !btn_last[bi];
    nb    = s1.hat_bits;
    ch    = nb ^ hat_last[hi];
    hbase = KEY_HAT_BASE + 5'({hi, 2'b00});

    case (s1.func)
      FN_AXIS: begin
        if (!pwm_en) begin
          if (v17 > prev17) begin
            if (v17 >= tn) begin
              if (st == AX_NEG) begin
                ev[n_ev[1:0]] = '{kn, 1'b0};
                n_ev = n_ev + 1'b1;
              end
              if (v17 >= tp) begin
                if (st != AX_POS) begin
                  ev[n_ev[1:0]] = '{kp, 1'b1};
                  n_ev = n_ev + 1'b1;
                end
                st_new = AX_POS;
              end else begin
                st_new = AX_CENTER;
              end
            end
          end else if (v17 < prev17) begin
            if (v17 < tp) begin
              if (st == AX_POS) begin
                ev[n_ev[1:0]] = '{kp, 1'b0};
                n_ev = n_ev + 1'b1;
              end
              if (v17 < tn) begin
                if (st != AX_NEG) begin
                  ev[n_ev[1:0]] = '{kn, 1'b1};
                  n_ev = n_ev + 1'b1;
                end
                st_new = AX_NEG;
              end else begin
                st_new = AX_CENTER;
              end
            end
          end
        end else begin
          if (v17 > 17'sd0 && pos_mag >= lvl) begin
            ns = AX_POS;
          end else if (v17 < 17'sd0 && neg_mag > lvl) begin
            ns = AX_NEG;
          end
          if (ns != st) begin
            // release the held key before pressing the other one
            if (st == AX_NEG) begin
              ev[n_ev[1:0]] = '{kn, 1'b0};
              n_ev = n_ev + 1'b1;
            end else if (st == AX_POS) begin
              ev[n_ev[1:0]] = '{kp, 1'b0};
              n_ev = n_ev + 1'b1;
            end
            if (ns == AX_NEG) begin
              ev[n_ev[1:0]] = '{kn, 1'b1};
              n_ev = n_ev + 1'b1;
            end else if (ns == AX_POS) begin
              ev[n_ev[1:0]] = '{kp, 1'b1};
              n_ev = n_ev + 1'b1;
            end
            st_new = ns;
          end
        end
      end
      FN_BUTTON: begin
        if (af_en) begin
          if (rise) begin
            on          = 1'b1;
            btn_clr_cnt = 1'b1;
          end
          btn_out = s1.button_level && on;
        end else begin
          btn_out = s1.button_level;
        end
        if (btn_out != btn_rep[bi]) begin
          ev[0] = '{KEY_BUTTON_BASE + 5'(bi), btn_out};
          n_ev  = 3'd1;
        end
      end
      FN_HAT: begin
        // order: right, up, left, down
        if (ch[1]) begin
          ev[n_ev[1:0]] = '{hbase + 5'd0, nb[1]};
          n_ev = n_ev + 1'b1;
        end
        if (ch[0]) begin
          ev[n_ev[1:0]] = '{hbase + 5'd1, nb[0]};
          n_ev = n_ev + 1'b1;
        end
        if (ch[3]) begin
          ev[n_ev[1:0]] = '{hbase + 5'd2, nb[3]};
          n_ev = n_ev + 1'b1;
        end
        if (ch[2]) begin
          ev[n_ev[1:0]] = '{hbase + 5'd3, nb[2]};
          n_ev = n_ev + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign push           = exec && s1_act && (n_ev != '0);
  assign push_data.last = 2'(n_ev - 1'b1);
  assign push_data.ev   = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        axis_last[i] <= '0;
        axis_st[i]   <= AX_CENTER;
      end
      for (int i = 0; i < HATS; i++) begin
        hat_last[i] <= '0;
      end
      btn_last <= '0;
      btn_rep  <= '0;
      phase    <= '0;
      af_count <= '0;
      af_raw   <= '0;
      prod     <= '0;
    end else begin
      phase <= phase_next;
      prod  <= prod_next;
      if (mst.done) begin
        af_count <= mod_rem;
      end
      if (exec && s1_act) begin
        case (s1.func)
          FN_TICK: begin
            af_count <= cnt_wrap;
            af_raw   <= cnt_wrap;
          end
          FN_AXIS: begin
            axis_last[ai] <= s1.axis_value;
            axis_st[ai]   <= st_new;
          end
          FN_BUTTON: begin
            btn_last[bi] <= s1.button_level;
            btn_rep[bi]  <= btn_out;
            if (btn_clr_cnt) begin
              af_count <= '0;
              af_raw   <= '0;
            end else if (af_en) begin
              // an autofire button settles the count at its reduced value
              af_raw <= af_count;
            end
          end
          FN_HAT: begin
            hat_last[hi] <= s1.hat_bits;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

>>> src/jke_queue.sv
module jke_queue import jke_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ev_group_t push_data,
  output logic      full,
  input  logic      pop,
  output ev_group_t pop_data,
  output logic      empty
);

  ev_group_t      mem [QDEPTH];
  logic [QAW-1:0] wr;
  logic [QAW-1:0] rd;
  logic [QAW:0]   level;

  assign full     = (level == (QAW+1)'(QDEPTH));
  assign empty    = (level == '0);
  assign pop_data = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wr <= wr + 1'b1;
      end
      if (pop) begin
        rd <= rd + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("event queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("event queue read while empty");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
      (empty || full) |-> (wr == rd))
    else $error("event queue pointers disagree with level");
  a_fill: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> !empty)
    else $error("event queue lost a request");

endmodule

>>> src/jke_back.sv
module jke_back import jke_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  ev_group_t q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output jke_out_t  out_data
);

  logic      g_valid;
  ev_group_t g;
  logic [1:0] pos;
  logic      out_free;
  logic      g_end;

  assign out_free = !out_valid || !out_stall;
  assign g_end    = g_valid && out_free && (pos == g.last);
  assign q_pop    = !q_empty && (!g_valid || g_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      g_valid   <= 1'b0;
      pos       <= '0;
    end else begin
      if (out_free) begin
        out_valid <= g_valid;
      end
      if (out_free && g_valid) begin
        pos <= g_end ? 2'd0 : pos + 1'b1;
      end
      if (q_pop) begin
        g_valid <= 1'b1;
      end else if (g_end) begin
        g_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && g_valid) begin
      out_data <= '{key_index:  g.ev[pos].key_index,
                    pressed:    g.ev[pos].pressed,
                    last_event: (pos == g.last)};
    end
    if (q_pop) begin
      g <= q_data;
    end
  end

endmodule

>>> src/joystick_to_key_events_core.sv
// Joystick to key event converter. An input request (tick, axis sample,
// button level or hat bits) is taken whenever the event queue has room,
// so requests can arrive back to back; each yields zero to four key events,
// delivered one per cycle from an output register while out_stall is low,
// and the event queue (four requests deep) sets how far input runs ahead
// of output. The first event passes the classify register, the event queue
// and the group register before it reaches the output register. Writing the
// autofire period starts a remainder pass on the autofire counter, during
// which in_stall is held high; other register writes take effect at once.
module joystick_to_key_events_core import jke_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  jke_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output jke_out_t          out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  logic      push;
  ev_group_t push_data;
  logic      q_full;
  logic      q_pop;
  ev_group_t q_data;
  logic      q_empty;

  jke_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  jke_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  jke_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> bench/joystick_to_key_events_core_tb.sv
module joystick_to_key_events_core_tb;
  import jke_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  jke_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  jke_out_t          out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  joystick_to_key_events_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial forever #4 clk = ~clk;

  // register mirror
  logic        cfg_enable = 1'b0;
  logic [14:0] cfg_thr    = 15'd16384;
  logic        cfg_pwm    = 1'b0;
  logic [15:0] cfg_step   = '0;
  logic        cfg_af     = 1'b0;
  logic [15:0] cfg_period = 16'd1000;
  logic [15:0] cfg_pulse  = 16'd500;

  // converter state as predicted
  logic signed [15:0] last_axis [AXES];
  axis_key_t          axis_state [AXES];
  logic               btn_level [BUTTONS];
  logic               btn_out [BUTTONS];
  logic [3:0]         hat_prev [HATS];
  logic [15:0]        phase_acc = '0;
  int unsigned        fire_count = 0;

  jke_in_t  pending_reqs [$];
  jke_out_t key_events_due [$];
  jke_out_t item_events [$];

  int  error_count = 0;
  int  reqs_taken = 0;
  int  events_checked = 0;
  int  settings_used = 0;
  int  hold_requests = 0;
  bit  steady = 1'b0;

  initial begin
    for (int k = 0; k < AXES; k++) begin
      last_axis[k] = '0;
      axis_state[k] = AX_CENTER;
    end
    for (int k = 0; k < BUTTONS; k++) begin
      btn_level[k] = 1'b0;
      btn_out[k] = 1'b0;
    end
    for (int k = 0; k < HATS; k++) hat_prev[k] = '0;
  end

  task automatic report_mismatch(string what);
    if (error_count < 40) $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic void push_event(int key, logic pr);
    jke_out_t e;
    e.key_index = 5'(key);
    e.pressed = pr;
    e.last_event = 1'b0;
    item_events.push_back(e);
  endfunction

  function automatic void predict_key_events(jke_in_t req);
    int              i, v, prev, t, base;
    int unsigned     p;
    longint unsigned lvl, mag;
    axis_key_t       st, ns;
    logic            lv, o, on;
    logic [3:0]      nb, ch;
    jke_out_t        e;
    if (!cfg_enable) return;
    item_events.delete();
    i = req.control_index;
    p = (cfg_period == 0) ? 1 : cfg_period;
    case (req.func)
      FN_TICK: begin
        phase_acc = phase_acc + cfg_step;
        fire_count = (fire_count + 1) % p;
      end
      FN_AXIS: if (i < AXES) begin
        v = $signed(req.axis_value);
        prev = $signed(last_axis[i]);
        st = axis_state[i];
        if (!cfg_pwm) begin
          t = int'((32'(cfg_thr) * 32767 + 16384) >> 15);
          if (v > prev) begin
            if (v >= -t) begin
              if (st == AX_NEG) push_event(2 * i, 1'b0);
              if (v >= t) begin
                if (st != AX_POS) push_event(2 * i + 1, 1'b1);
                st = AX_POS;
              end else begin
                st = AX_CENTER;
              end
            end
          end else if (v < prev) begin
            if (v < t) begin
              if (st == AX_POS) push_event(2 * i + 1, 1'b0);
              if (v < -t) begin
                if (st != AX_NEG) push_event(2 * i, 1'b1);
                st = AX_NEG;
              end else begin
                st = AX_CENTER;
              end
            end
          end
        end else begin
          // phase-driven level, dead band at the threshold
          lvl = 64'(phase_acc) * 64'(32768 - int'(cfg_thr)) + (64'(cfg_thr) << 15);
          ns = AX_CENTER;
          if (v > 0) begin
            mag = 64'(v) * 65536;
            if (mag >= lvl) ns = AX_POS;
          end else if (v < 0) begin
            mag = 64'(-v) * 65536;
            if (mag > lvl) ns = AX_NEG;
          end
          if (ns != st) begin
            if (st == AX_NEG) push_event(2 * i, 1'b0);
            else if (st == AX_POS) push_event(2 * i + 1, 1'b0);
            if (ns == AX_NEG) push_event(2 * i, 1'b1);
            else if (ns == AX_POS) push_event(2 * i + 1, 1'b1);
            st = ns;
          end
        end
        axis_state[i] = st;
        last_axis[i] = req.axis_value;
      end
      FN_BUTTON: if (i < BUTTONS) begin
        lv = req.button_level;
        o = lv;
        if (cfg_af) begin
          if (fire_count >= p) fire_count = fire_count % p;
          on = (fire_count < cfg_pulse);
          if (lv && !btn_level[i]) begin
            on = 1'b1;
            fire_count = 0;
          end
          o = lv && on;
        end
        btn_level[i] = lv;
        if (o != btn_out[i]) begin
          push_event(int'(KEY_BUTTON_BASE) + i, o);
          btn_out[i] = o;
        end
      end
      FN_HAT: if (i < HATS) begin
        nb = req.hat_bits;
        ch = nb ^ hat_prev[i];
        base = int'(KEY_HAT_BASE) + 4 * i;
        // right, up, left, down
        if (ch[1]) push_event(base + 0, nb[1]);
        if (ch[0]) push_event(base + 1, nb[0]);
        if (ch[3]) push_event(base + 2, nb[3]);
        if (ch[2]) push_event(base + 3, nb[2]);
        hat_prev[i] = nb;
      end
      default: ;
    endcase
    if (item_events.size() > 0) begin
      e = item_events.pop_back();
      e.last_event = 1'b1;
      item_events.push_back(e);
    end
    foreach (item_events[k]) key_events_due.push_back(item_events[k]);
  endfunction

  // sender: bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_key_events(in_data);
        reqs_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (!steady && gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                   : $urandom_range(0, 3);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall modes; long holds on demand
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int pat_cnt = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      hold_left = 160;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 80);
      end else begin
        mode_left--;
      end
      pat_cnt = (pat_cnt + 1) % 5;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= (pat_cnt < 2);
      endcase
    end
  end

  always @(posedge clk) begin : event_check
    jke_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (key_events_due.size() == 0) begin
        report_mismatch($sformatf("unexpected event key %0d pressed %0b",
                                  out_data.key_index, out_data.pressed));
      end else begin
        want = key_events_due.pop_front();
        events_checked++;
        if (out_data.key_index !== want.key_index)
          report_mismatch($sformatf("key_index %0d, want %0d",
                                    out_data.key_index, want.key_index));
        if (out_data.pressed !== want.pressed)
          report_mismatch($sformatf("pressed %0b, want %0b on key %0d",
                                    out_data.pressed, want.pressed, want.key_index));
        if (out_data.last_event !== want.last_event)
          report_mismatch($sformatf("last_event %0b, want %0b on key %0d",
                                    out_data.last_event, want.last_event, want.key_index));
      end
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DW'(val);
    case (idx)
      CFG_ENABLE:    cfg_enable = val[0];
      CFG_THRESHOLD: cfg_thr = val[14:0];
      CFG_PWM_EN:    cfg_pwm = val[0];
      CFG_PWM_STEP:  cfg_step = val[15:0];
      CFG_AF_EN:     cfg_af = val[0];
      CFG_AF_PERIOD: cfg_period = val[15:0];
      CFG_AF_PULSE:  cfg_pulse = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all requests taken, all events seen, then room for event-free requests
  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || key_events_due.size() != 0)
      @(negedge clk);
    repeat (32) @(negedge clk);
  endtask

  function automatic jke_in_t make_req(func_t f, int idx, int val, bit lv, int bits);
    jke_in_t r;
    r.func = f;
    r.control_index = 3'(idx);
    r.axis_value = 16'(val);
    r.button_level = lv;
    r.hat_bits = 4'(bits);
    return r;
  endfunction

  // mix 0: everything, 1: mostly axis and ticks, 2: mostly buttons and ticks
  function automatic jke_in_t rand_req(int mix);
    jke_in_t r;
    int      roll, t, v;
    r.control_index = 3'($urandom_range(0, 7));
    r.axis_value = 16'($urandom);
    r.button_level = 1'($urandom);
    r.hat_bits = 4'($urandom);
    roll = $urandom_range(0, 99);
    case (mix)
      1:       r.func = (roll < 35) ? FN_TICK : (roll < 85) ? FN_AXIS :
                        (roll < 90) ? FN_BUTTON : FN_HAT;
      2:       r.func = (roll < 45) ? FN_TICK : (roll < 85) ? FN_BUTTON :
                        (roll < 90) ? FN_AXIS : FN_HAT;
      default: r.func = (roll < 15) ? FN_TICK : (roll < 55) ? FN_AXIS :
                        (roll < 75) ? FN_BUTTON : FN_HAT;
    endcase
    if (r.func == FN_AXIS || r.func == FN_BUTTON) begin
      if ($urandom_range(0, 7) != 0) r.control_index = 3'($urandom_range(0, 3));
    end else if (r.func == FN_HAT) begin
      if ($urandom_range(0, 5) != 0) r.control_index = 3'($urandom_range(0, 1));
    end
    if (r.func == FN_AXIS) begin
      roll = $urandom_range(0, 9);
      t = int'((32'(cfg_thr) * 32767 + 16384) >> 15);
      if (roll < 2) begin
        case ($urandom_range(0, 2))
          0:       v = 32767;
          1:       v = -32768;
          default: v = 0;
        endcase
        r.axis_value = 16'(v);
      end else if (roll < 6) begin
        // around the hysteresis edges
        v = ($urandom_range(0, 1) ? t : -t) + $urandom_range(0, 4) - 2;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.axis_value = 16'(v);
      end
    end
    return r;
  endfunction

  task automatic run_phase(int n, int mix, bit no_gap, bit squeeze);
    @(negedge clk);
    settings_used++;
    steady = no_gap;
    if (squeeze) hold_requests++;
    repeat (n) pending_reqs.push_back(rand_req(mix));
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // block disabled: everything dropped
    @(negedge clk);
    pending_reqs.push_back(make_req(FN_HAT, 0, 0, 1'b0, 15));
    pending_reqs.push_back(make_req(FN_AXIS, 0, 32767, 1'b0, 0));
    pending_reqs.push_back(make_req(FN_BUTTON, 1, 0, 1'b1, 0));
    wait_idle();

    write_reg(CFG_ENABLE, 1);
    @(negedge clk);
    pending_reqs.push_back(make_req(FN_AXIS, 0, 32767, 1'b0, 0));
    pending_reqs.push_back(make_req(FN_AXIS, 0, -32768, 1'b0, 0));
    pending_reqs.push_back(make_req(FN_AXIS, 0, 0, 1'b0, 0));
    pending_reqs.push_back(make_req(FN_AXIS, 7, 16383, 1'b0, 0));
    pending_reqs.push_back(make_req(FN_AXIS, 7, -1, 1'b0, 0));
    pending_reqs.push_back(make_req(FN_BUTTON, 0, 0, 1'b1, 0));
    pending_reqs.push_back(make_req(FN_BUTTON, 7, 0, 1'b1, 0));
    pending_reqs.push_back(make_req(FN_BUTTON, 0, 0, 1'b0, 0));
    pending_reqs.push_back(make_req(FN_BUTTON, 0, 0, 1'b0, 0));
    pending_reqs.push_back(make_req(FN_HAT, 0, 0, 1'b0, 15));
    pending_reqs.push_back(make_req(FN_HAT, 1, 0, 1'b0, 5));
    pending_reqs.push_back(make_req(FN_HAT, 0, 0, 1'b0, 0));
    pending_reqs.push_back(make_req(FN_HAT, 3, 0, 1'b0, 15));  // no such hat
    pending_reqs.push_back(make_req(FN_HAT, 1, 0, 1'b0, 10));
    pending_reqs.push_back(make_req(FN_TICK, 0, 0, 1'b0, 0));
    wait_idle();

    // zero period behaves as one
    write_reg(CFG_AF_EN, 1);
    write_reg(CFG_AF_PERIOD, 0);
    write_reg(CFG_AF_PULSE, 1);
    @(negedge clk);
    pending_reqs.push_back(make_req(FN_BUTTON, 2, 0, 1'b1, 0));
    pending_reqs.push_back(make_req(FN_TICK, 0, 0, 1'b0, 0));
    pending_reqs.push_back(make_req(FN_BUTTON, 2, 0, 1'b1, 0));
    wait_idle();

    write_reg(CFG_AF_EN, 0);
    write_reg(CFG_PWM_EN, 1);
    write_reg(CFG_THRESHOLD, 0);
    @(negedge clk);
    pending_reqs.push_back(make_req(FN_AXIS, 1, 1, 1'b0, 0));
    pending_reqs.push_back(make_req(FN_AXIS, 1, -1, 1'b0, 0));
    wait_idle();

    // random part
    write_reg(CFG_PWM_EN, 0);
    write_reg(CFG_THRESHOLD, $urandom_range(0, 32767));
    run_phase(30, 0, 1'b0, 1'b0);
    write_reg(CFG_THRESHOLD, 0);
    run_phase(25, 0, 1'b1, 1'b1);
    write_reg(CFG_THRESHOLD, 32767);
    run_phase(25, 0, 1'b0, 1'b0);

    write_reg(CFG_PWM_EN, 1);
    write_reg(CFG_PWM_STEP, $urandom_range(1, 65535));
    write_reg(CFG_THRESHOLD, $urandom_range(0, 32767));
    run_phase(35, 1, 1'b0, 1'b0);
    write_reg(CFG_THRESHOLD, 0);
    write_reg(CFG_PWM_STEP, 65535);
    run_phase(20, 1, 1'b0, 1'b0);
    write_reg(CFG_THRESHOLD, 32767);
    write_reg(CFG_PWM_STEP, 1);
    run_phase(20, 1, 1'b0, 1'b0);

    // back to hysteresis with key states carried over
    write_reg(CFG_PWM_EN, 0);
    write_reg(CFG_THRESHOLD, 16384);
    run_phase(20, 1, 1'b0, 1'b0);

    write_reg(CFG_AF_EN, 1);
    write_reg(CFG_AF_PERIOD, $urandom_range(1, 8));
    write_reg(CFG_AF_PULSE, $urandom_range(0, int'(cfg_period) + 1));
    run_phase(35, 2, 1'b1, 1'b1);
    write_reg(CFG_AF_PERIOD, 0);
    write_reg(CFG_AF_PULSE, 0);
    run_phase(20, 2, 1'b0, 1'b0);
    write_reg(CFG_AF_PERIOD, 65535);
    write_reg(CFG_AF_PULSE, 65535);
    run_phase(20, 2, 1'b0, 1'b0);

    write_reg(CFG_ENABLE, 0);
    run_phase(10, 0, 1'b0, 1'b0);
    write_reg(CFG_ENABLE, 1);
    write_reg(CFG_AF_PERIOD, $urandom_range(2, 6));
    write_reg(CFG_AF_PULSE, $urandom_range(1, 3));
    write_reg(CFG_THRESHOLD, $urandom_range(0, 32767));
    run_phase(40, 0, 1'b1, 1'b0);

    $display("covered %0d requests over %0d register settings, %0d key events checked",
             reqs_taken, settings_used, events_checked);
    $display("hysteresis, pwm and autofire modes run with input gaps and output holds");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d events outstanding", key_events_due.size());
    $display("status: fail");
    $finish;
  end

endmodule
